// ===== rtl/core/tms_pkg.sv =====
// Shared types and constants for the tone and melody sequencer.
`timescale 1ns / 1ps
package tms_pkg;

  // Default number of entries in the melody table.
  localparam int MELODY_DEPTH_DEF = 64;

  // Field widths of the command and result words.
  localparam int CMD_W   = 3;
  localparam int FREQ_W  = 16;
  localparam int DUR_W   = 16;
  localparam int IDX_W   = 6;
  localparam int COUNT_W = 7;

  // Command codes carried in the input tuser field.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 3'd0,
    CMD_TONE = 3'd1,
    CMD_OFF  = 3'd2,
    CMD_BEEP = 3'd3,
    CMD_LOAD = 3'd4,
    CMD_PLAY = 3'd5
  } cmd_t;

  // Play mode, one-hot.
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_TONE   = 4'b0010,
    MODE_BEEP   = 4'b0100,
    MODE_MELODY = 4'b1000
  } mode_t;

  // One melody table entry.
  typedef struct packed {
    logic [FREQ_W-1:0] tone;
    logic [DUR_W-1:0]  length;
  } note_t;

  // One result word.
  typedef struct packed {
    logic [FREQ_W-1:0] tone_frequency;
    logic              active;
    logic              melody_playing;
  } result_t;

endpackage

// ===== rtl/core/tms_note_mem.sv =====
// Melody table memory with one write port and one registered read port.
`timescale 1ns / 1ps
module tms_note_mem #(
  parameter int DEPTH = tms_pkg::MELODY_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  tms_pkg::note_t wdata_i,
  input  logic [AW-1:0]  raddr_i,
  output tms_pkg::note_t rdata_o
);
  import tms_pkg::*;

  note_t         mem [DEPTH];
  note_t         rd_r;
  logic [AW-1:0] rd_addr_r;
  logic          last_we_r;
  logic [AW-1:0] last_waddr_r;
  note_t         last_wdata_r;

  // Storage and registered read; the read returns the old contents on a collision.
  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_r         <= mem[raddr_i];
    rd_addr_r    <= raddr_i;
    last_waddr_r <= waddr_i;
    last_wdata_r <= wdata_i;
  end

  // Remember whether a write happened at the last edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_we_r <= 1'b0;
    end else begin
      last_we_r <= we_i;
    end
  end

  // Forward a write that landed on the entry being read at the same edge.
  assign rdata_o = (last_we_r && (last_waddr_r == rd_addr_r)) ? last_wdata_r : rd_r;

endmodule

// ===== rtl/core/tms_ctrl.sv =====
// Command decoder and play state of the sequencer.
`timescale 1ns / 1ps
module tms_ctrl #(
  parameter int DEPTH = tms_pkg::MELODY_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire_i,
  input  logic [tms_pkg::CMD_W-1:0]     cmd_i,
  input  logic [tms_pkg::FREQ_W-1:0]    freq_i,
  input  logic [tms_pkg::DUR_W-1:0]     dur_i,
  input  logic [tms_pkg::IDX_W-1:0]     idx_i,
  input  logic [tms_pkg::COUNT_W-1:0]   count_i,
  input  tms_pkg::note_t                next_note_i,
  output logic                          we_o,
  output logic [AW-1:0]                 waddr_o,
  output tms_pkg::note_t                wdata_o,
  output logic [AW-1:0]                 raddr_o,
  output tms_pkg::result_t              result_o
);
  import tms_pkg::*;

  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = LW + 1;
  localparam int SW = (LW > COUNT_W) ? LW : COUNT_W;
  localparam int IW = (LW > IDX_W) ? LW : IDX_W;

  mode_t             mode_r, mode_nxt;
  logic [DUR_W-1:0]  time_r, time_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [FREQ_W-1:0] tone_r, tone_nxt;
  note_t             zero_note_r;
  logic              silence;
  logic [SW-1:0]     count_ext;
  logic [SW-1:0]     len_sat;
  logic              last_note;

  // Melody length saturated to the table depth.
  assign count_ext = SW'(count_i);
  assign len_sat   = (count_ext > SW'(DEPTH)) ? SW'(DEPTH) : count_ext;
  assign last_note = (CW'(pos_r) + CW'(1)) >= CW'(len_r);

  // Table write for the load command.
  assign waddr_o = AW'(idx_i);
  assign wdata_o = '{tone: freq_i, length: dur_i};

  // Next state for the word being processed.
  always_comb begin
    mode_nxt = mode_r;
    time_nxt = time_r;
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    tone_nxt = tone_r;
    silence  = 1'b0;
    we_o     = 1'b0;
    if (fire_i) begin
      unique case (cmd_i)
        CMD_TICK: begin
          if (mode_r == MODE_BEEP || mode_r == MODE_MELODY) begin
            if (time_r > DUR_W'(1)) begin
              time_nxt = time_r - DUR_W'(1);
            end else if (mode_r == MODE_BEEP || last_note) begin
              silence = 1'b1;
            end else begin
              pos_nxt  = pos_r + AW'(1);
              tone_nxt = next_note_i.tone;
              time_nxt = next_note_i.length;
            end
          end
        end
        CMD_TONE: begin
          mode_nxt = MODE_TONE;
          tone_nxt = freq_i;
          time_nxt = '0;
          pos_nxt  = '0;
          len_nxt  = '0;
        end
        CMD_OFF: begin
          silence = 1'b1;
        end
        CMD_BEEP: begin
          mode_nxt = MODE_BEEP;
          tone_nxt = freq_i;
          time_nxt = dur_i;
          pos_nxt  = '0;
          len_nxt  = '0;
        end
        CMD_LOAD: begin
          we_o = (IW'(idx_i) < IW'(DEPTH));
        end
        CMD_PLAY: begin
          if (count_i != '0) begin
            mode_nxt = MODE_MELODY;
            len_nxt  = LW'(len_sat);
            pos_nxt  = '0;
            tone_nxt = zero_note_r.tone;
            time_nxt = zero_note_r.length;
          end
        end
        default: begin
        end
      endcase
      if (silence) begin
        mode_nxt = MODE_IDLE;
        time_nxt = '0;
        pos_nxt  = '0;
        len_nxt  = '0;
        tone_nxt = '0;
      end
    end
  end

  // Prefetch the note after the one now current.
  assign raddr_o = pos_nxt + AW'(1);

  // Result shows the state after the command.
  assign result_o = '{
    tone_frequency: (mode_nxt != MODE_IDLE) ? tone_nxt : '0,
    active:         (mode_nxt != MODE_IDLE),
    melody_playing: (mode_nxt == MODE_MELODY)
  };

  // Play state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      time_r <= '0;
      pos_r  <= '0;
      len_r  <= '0;
      tone_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      time_r <= time_nxt;
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      tone_r <= tone_nxt;
    end
  end

  // Copy of the first table entry, so that play can start without a read.
  always_ff @(posedge clk) begin
    if (we_o && (waddr_o == '0)) begin
      zero_note_r <= wdata_o;
    end
  end

endmodule

// ===== rtl/core/tone_and_melody_sequencer_core.sv =====
// Top level of the tone and melody sequencer: input register, control, table, result register.
`timescale 1ns / 1ps
// A word accepted into the input register is processed once the result register can take
// it; its result is then registered and offered on the out_ side.
// Throughput: one word per cycle while the output side is not stalled; each word reads the
// table to prefetch the next melody note through the single registered read port.
// Reset clears the handshake and the play state; the melody table is not cleared.
module tone_and_melody_sequencer_core #(
  parameter int MELODY_DEPTH = tms_pkg::MELODY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // frequency[15:0], duration[31:16], note_index[37:32],
                                  // note_count[44:38], zero fill[47:45]
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // tone_frequency[15:0], active[16], melody_playing[17],
                                  // zero fill[23:18]
);
  import tms_pkg::*;

  localparam int AW = (MELODY_DEPTH > 1) ? $clog2(MELODY_DEPTH) : 1;

  logic               in_valid_r;
  logic [CMD_W-1:0]   in_cmd_r;
  logic [FREQ_W-1:0]  in_freq_r;
  logic [DUR_W-1:0]   in_dur_r;
  logic [IDX_W-1:0]   in_idx_r;
  logic [COUNT_W-1:0] in_count_r;
  logic               out_valid_r;
  result_t            out_res_r;
  logic               fire;
  logic               in_take;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  note_t              wdata;
  note_t              next_note;
  result_t            result;

  // Handshake: the input register drains whenever the result register can take a word.
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;
  assign in_take   = in_tvalid && in_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r   <= in_tuser;
      in_freq_r  <= in_tdata[15:0];
      in_dur_r   <= in_tdata[31:16];
      in_idx_r   <= in_tdata[37:32];
      in_count_r <= in_tdata[44:38];
    end
  end

  // Command processing and play state.
  tms_ctrl #(
    .DEPTH (MELODY_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire_i      (fire),
    .cmd_i       (in_cmd_r),
    .freq_i      (in_freq_r),
    .dur_i       (in_dur_r),
    .idx_i       (in_idx_r),
    .count_i     (in_count_r),
    .next_note_i (next_note),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .result_o    (result)
  );

  // Melody table.
  tms_note_mem #(
    .DEPTH (MELODY_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (next_note)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.melody_playing, out_res_r.active,
                       out_res_r.tone_frequency};

  // The input side stalls only while a result waits on the output side.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a waiting result");

  // A processed word always shows up as a result at the next edge.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_tvalid && (out_res_r == $past(result))))
    else $error("processed word did not reach the result register");

  // A silent result carries no frequency and no melody flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_res_r.active) |->
      ((out_res_r.tone_frequency == '0) && !out_res_r.melody_playing))
    else $error("inactive result with tone or melody flag");

endmodule
